// ===== rtl/core/tci_pkg.sv =====
package tci_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_BI_RD,
    ST_BI_WR,
    ST_DONE
  } tci_state_t;

  // Hit level codes
  localparam logic [1:0] HIT_L1   = 2'd0;
  localparam logic [1:0] HIT_L2   = 2'd1;
  localparam logic [1:0] HIT_NONE = 2'd2;

  // Eviction kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLEAN = 2'd1;
  localparam logic [1:0] EV_DIRTY = 2'd2;

  // Register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_MASK  = 16'hB400;
  localparam logic [7:0]  AGE_MAX    = 8'd255;

  // Settings seen by the sequencer
  typedef struct packed {
    logic        policy;
    logic [15:0] seed;
    logic        seed_load;
  } tci_cfg_t;

  // One Galois step of the victim LFSR
  function automatic logic [15:0] lfsr_step(logic [15:0] x);
    lfsr_step = (x >> 1) ^ (x[0] ? LFSR_MASK : 16'd0);
  endfunction

  // Saturating age increment
  function automatic logic [7:0] age_inc(logic [7:0] a);
    age_inc = (a == AGE_MAX) ? a : a + 8'd1;
  endfunction

endpackage

// ===== rtl/core/tci_req_if.sv =====
interface tci_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink (input valid, input mode, input address, output ready);
endinterface

// ===== rtl/core/tci_rsp_if.sv =====
interface tci_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] hit_level;
  logic [1:0] l1_eviction;
  logic [1:0] l2_eviction;
  logic       back_invalidated;

  modport source (output valid, output hit_level, output l1_eviction,
                  output l2_eviction, output back_invalidated, input ready);
  modport sink (input valid, input hit_level, input l1_eviction,
                input l2_eviction, input back_invalidated, output ready);
endinterface

// ===== rtl/core/tci_ram.sv =====
module tci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tci_cfg.sv =====
module tci_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output tci_pkg::tci_cfg_t cfg
);
  import tci_pkg::*;

  logic        policy;
  logic [15:0] seed;
  logic        wr_en;
  logic        idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
      seed   <= SEED_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_POLICY: policy <= pwdata[0];
        REG_SEED:   seed   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      REG_POLICY: prdata = {31'd0, policy};
      REG_SEED:   prdata = {16'd0, seed};
      default:    prdata = '0;
    endcase
  end

  assign cfg.policy    = policy;
  assign cfg.seed      = pwdata[15:0];
  assign cfg.seed_load = wr_en & (idx == REG_SEED);
endmodule

// ===== rtl/core/tci_ctrl.sv =====
module tci_ctrl #(
  parameter int ADDR_BITS   = 32,
  parameter int BLOCK_BYTES = 64,
  parameter int L1_SETS     = 64,
  parameter int L1_WAYS     = 4,
  parameter int L2_SETS     = 256,
  parameter int L2_WAYS     = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tci_pkg::tci_cfg_t cfg,
  tci_req_if.sink           req,
  tci_rsp_if.source         rsp
);
  import tci_pkg::*;

  // Address split; set counts are powers of two
  localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int OFF   = $clog2(BLOCK_BYTES);
  localparam int S1B   = $clog2(L1_SETS);
  localparam int S2B   = $clog2(L2_SETS);
  localparam int S1W   = (S1B > 0) ? S1B : 1;
  localparam int S2W   = (S2B > 0) ? S2B : 1;
  localparam int T1R   = AW - OFF - S1B;
  localparam int T2R   = AW - OFF - S2B;
  localparam int T1W   = (T1R > 0) ? T1R : 1;
  localparam int T2W   = (T2R > 0) ? T2R : 1;
  localparam int E1W   = T1W + 10;
  localparam int E2W   = T2W + 10;
  localparam int R1W   = L1_WAYS * E1W;
  localparam int R2W   = L2_WAYS * E2W;
  localparam int V1W   = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int V2W   = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int CLR_ROWS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CNTW  = $clog2(CLR_ROWS + 1);
  localparam logic [31:0] AMASK = 32'((64'd1 << AW) - 64'd1);
  localparam logic [31:0] M1    = 32'(L1_SETS - 1);
  localparam logic [31:0] M2    = 32'(L2_SETS - 1);

  // Reciprocals of the way counts; exact quotient for any 16-bit value
  localparam int RSH = 21;
  localparam logic [21:0] RCP1 = 22'(((1 << RSH) + L1_WAYS - 1) / L1_WAYS);
  localparam logic [21:0] RCP2 = 22'(((1 << RSH) + L2_WAYS - 1) / L2_WAYS);

  function automatic logic [31:0] block_of(logic [31:0] a);
    block_of = (a & AMASK) >> OFF;
  endfunction

  // Remainder of a 16-bit value by a way count through its reciprocal
  function automatic logic [15:0] mod_by(logic [15:0] x, logic [21:0] rcp,
                                         logic [4:0] n);
    logic [37:0] p;
    logic [15:0] q;
    logic [20:0] qn;
    p  = 38'(x) * 38'(rcp);
    q  = p[RSH +: 16];
    qn = 21'(q) * 21'(n);
    mod_by = x - qn[15:0];
  endfunction

  tci_state_t state, state_next;

  logic [CNTW-1:0] cnt;
  logic            wr;
  logic [15:0]     lfsr, lfsr_next;
  logic [S1W-1:0]  s1, es, es_next;
  logic [S2W-1:0]  s2;
  logic [T1W-1:0]  t1, et, et_next;
  logic [T2W-1:0]  t2;
  logic [1:0]      res_hit, res_ev1, res_ev2, hit_next, ev1_next, ev2_next;
  logic            res_binv, binv_next;

  // Memory ports
  logic           we1, we2;
  logic [S1W-1:0] wa1, ra1;
  logic [S2W-1:0] wa2, ra2;
  logic [R1W-1:0] wd1, rd1, row1_look, row1_bi;
  logic [R2W-1:0] wd2, rd2, row2_look;

  tci_ram #(.WIDTH(R1W), .DEPTH(L1_SETS)) u_l1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1)
  );
  tci_ram #(.WIDTH(R2W), .DEPTH(L2_SETS)) u_l2 (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .raddr(ra2), .rdata(rd2)
  );

  // Split the held address
  logic [31:0] blk_q;
  always_comb begin
    s1 = S1W'(blk_q & M1);
    t1 = T1W'(blk_q >> S1B);
    s2 = S2W'(blk_q & M2);
    t2 = T2W'(blk_q >> S2B);
  end

  // Unpacked rows
  logic [T1W-1:0]     tag1 [L1_WAYS];
  logic [L1_WAYS-1:0] val1, drt1;
  logic [7:0]         age1 [L1_WAYS];
  logic [T2W-1:0]     tag2 [L2_WAYS];
  logic [L2_WAYS-1:0] val2, drt2;
  logic [7:0]         age2 [L2_WAYS];

  always_comb begin
    for (int w = 0; w < L1_WAYS; w++) begin
      tag1[w] = rd1[w*E1W+10 +: T1W];
      val1[w] = rd1[w*E1W+9];
      drt1[w] = rd1[w*E1W+8];
      age1[w] = rd1[w*E1W +: 8];
    end
    for (int w = 0; w < L2_WAYS; w++) begin
      tag2[w] = rd2[w*E2W+10 +: T2W];
      val2[w] = rd2[w*E2W+9];
      drt2[w] = rd2[w*E2W+8];
      age2[w] = rd2[w*E2W +: 8];
    end
  end

  // Lookup, victim choice and row update
  logic           hit1, hit2, inv1_any, inv2_any, bi_need, bi_hit;
  logic [V1W-1:0] hw1, iw1, lw1, vw1;
  logic [V2W-1:0] hw2, iw2, lw2, vw2;
  logic [V1W-1:0] bw;
  logic [7:0]     best1, best2;
  logic [15:0]    lfsr_a, lfsr_b;
  logic [31:0]    eb;

  always_comb begin
    hit1 = 1'b0; hw1 = '0; inv1_any = 1'b0; iw1 = '0;
    hit2 = 1'b0; hw2 = '0; inv2_any = 1'b0; iw2 = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (val1[w] && tag1[w] == t1) begin hit1 = 1'b1; hw1 = V1W'(w); end
      if (!val1[w]) begin inv1_any = 1'b1; iw1 = V1W'(w); end
    end
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (val2[w] && tag2[w] == t2) begin hit2 = 1'b1; hw2 = V2W'(w); end
      if (!val2[w]) begin inv2_any = 1'b1; iw2 = V2W'(w); end
    end
    best1 = age1[0]; lw1 = '0;
    for (int w = 1; w < L1_WAYS; w++)
      if (age1[w] > best1) begin best1 = age1[w]; lw1 = V1W'(w); end
    best2 = age2[0]; lw2 = '0;
    for (int w = 1; w < L2_WAYS; w++)
      if (age2[w] > best2) begin best2 = age2[w]; lw2 = V2W'(w); end

    // Victims: invalid way first, then LFSR or oldest
    lfsr_a = (cfg.policy && !hit1) ? lfsr_step(lfsr) : lfsr;
    lfsr_b = (cfg.policy && !hit1 && !hit2) ? lfsr_step(lfsr_a) : lfsr_a;
    if (inv1_any) vw1 = iw1;
    else if (cfg.policy) vw1 = V1W'(mod_by(lfsr, RCP1, 5'(L1_WAYS)));
    else vw1 = lw1;
    if (inv2_any) vw2 = iw2;
    else if (cfg.policy) vw2 = V2W'(mod_by(lfsr_a, RCP2, 5'(L2_WAYS)));
    else vw2 = lw2;

    // L1 row after hit or fill
    row1_look = rd1;
    for (int w = 0; w < L1_WAYS; w++) begin
      row1_look[w*E1W +: 8] = age_inc(age1[w]);
      if (hit1 && hw1 == V1W'(w)) begin
        row1_look[w*E1W +: 8] = '0;
        row1_look[w*E1W+8]    = drt1[w] | wr;
      end
      if (!hit1 && vw1 == V1W'(w)) begin
        row1_look[w*E1W +: 8]      = '0;
        row1_look[w*E1W+8]         = wr;
        row1_look[w*E1W+9]         = 1'b1;
        row1_look[w*E1W+10 +: T1W] = t1;
      end
    end

    // L2 row after hit or fill
    row2_look = rd2;
    for (int w = 0; w < L2_WAYS; w++) begin
      row2_look[w*E2W +: 8] = age_inc(age2[w]);
      if (hit2 && hw2 == V2W'(w)) begin
        row2_look[w*E2W +: 8] = '0;
        row2_look[w*E2W+8]    = drt2[w] | wr;
      end
      if (!hit2 && vw2 == V2W'(w)) begin
        row2_look[w*E2W +: 8]      = '0;
        row2_look[w*E2W+8]         = 1'b0;
        row2_look[w*E2W+9]         = 1'b1;
        row2_look[w*E2W+10 +: T2W] = t2;
      end
    end

    // Kinds and back-invalidation target
    if (hit1) hit_next = HIT_L1;
    else if (hit2) hit_next = HIT_L2;
    else hit_next = HIT_NONE;
    ev1_next = hit1 ? EV_NONE : (!val1[vw1] ? EV_NONE : (drt1[vw1] ? EV_DIRTY : EV_CLEAN));
    ev2_next = (hit1 || hit2) ? EV_NONE :
               (!val2[vw2] ? EV_NONE : (drt2[vw2] ? EV_DIRTY : EV_CLEAN));
    bi_need  = !hit1 && !hit2 && val2[vw2];
    eb       = (32'(tag2[vw2]) << S2B) | 32'(s2);
    es_next  = S1W'(eb & M1);
    et_next  = T1W'(eb >> S1B);

    // Back-invalidation on the reread L1 row
    bi_hit = 1'b0; bw = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--)
      if (val1[w] && tag1[w] == et) begin bi_hit = 1'b1; bw = V1W'(w); end
    row1_bi = rd1;
    for (int w = 0; w < L1_WAYS; w++) begin
      row1_bi[w*E1W +: 8] = age_inc(age1[w]);
      if (bw == V1W'(w)) row1_bi[w*E1W +: E1W] = '0;
    end
    binv_next = bi_hit;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt == CNTW'(CLR_ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_LOOK;
      ST_LOOK:  state_next = bi_need ? ST_BI_RD : ST_DONE;
      ST_BI_RD: state_next = ST_BI_WR;
      ST_BI_WR: state_next = ST_DONE;
      ST_DONE:  if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Memory control and handshake outputs
  always_comb begin
    req.ready = 1'b0;
    we1 = 1'b0; we2 = 1'b0;
    wa1 = s1; wa2 = s2;
    wd1 = row1_look; wd2 = row2_look;
    ra1 = S1W'(block_of(req.address) & M1);
    ra2 = S2W'(block_of(req.address) & M2);
    unique case (state)
      ST_CLEAR: begin
        we1 = (cnt < CNTW'(L1_SETS));
        we2 = (cnt < CNTW'(L2_SETS));
        wa1 = S1W'(cnt);
        wa2 = S2W'(cnt);
        wd1 = '0;
        wd2 = '0;
      end
      ST_IDLE:  req.ready = 1'b1;
      ST_LOOK: begin
        we1 = 1'b1;
        we2 = !hit1;
      end
      ST_BI_RD: ra1 = es;
      ST_BI_WR: begin
        we1 = bi_hit;
        wa1 = es;
        wd1 = row1_bi;
      end
      default: ;
    endcase
  end

  // LFSR: reload on seed write, advance on victim choices
  always_comb begin
    lfsr_next = lfsr;
    if (cfg.seed_load) lfsr_next = cfg.seed;
    else if (state == ST_LOOK) lfsr_next = lfsr_b;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      lfsr      <= SEED_RESET;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      lfsr  <= lfsr_next;
      if (state == ST_CLEAR) cnt <= cnt + CNTW'(1);
      if (state == ST_DONE && (!rsp.valid || rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Item and result holding registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      wr    <= req.mode;
      blk_q <= block_of(req.address);
    end
    if (state == ST_LOOK) begin
      res_hit  <= hit_next;
      res_ev1  <= ev1_next;
      res_ev2  <= ev2_next;
      res_binv <= 1'b0;
      es       <= es_next;
      et       <= et_next;
    end
    if (state == ST_BI_WR) res_binv <= binv_next;
    if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.hit_level        <= res_hit;
      rsp.l1_eviction      <= res_ev1;
      rsp.l2_eviction      <= res_ev2;
      rsp.back_invalidated <= res_binv;
    end
  end
endmodule

// ===== rtl/core/two_level_inclusive_cache_tags.sv =====
// An item goes through the lookup and done states to a registered result; the
// BI read and BI write states come between when an L2 victim has to be looked
// up in L1 for back-invalidation (second L1 row access). A new item waits for
// the last one's read-modify-write of the L1 and L2 tag rows and its result.
// A clearing pass after reset writes every set row before the first item.
module two_level_inclusive_cache_tags #(
  parameter int ADDR_BITS   = 32,
  parameter int BLOCK_BYTES = 64,
  parameter int L1_SETS     = 64,
  parameter int L1_WAYS     = 4,
  parameter int L2_SETS     = 256,
  parameter int L2_WAYS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tci_req_if.sink     req,
  tci_rsp_if.source   rsp
);
  import tci_pkg::*;

  tci_cfg_t cfg;

  tci_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  tci_ctrl #(
    .ADDR_BITS(ADDR_BITS), .BLOCK_BYTES(BLOCK_BYTES),
    .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS),
    .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)
  ) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp)
  );
endmodule

// ===== dv/cache_tags_checker.sv =====
module cache_tags_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  tci_req_if.sink     req,
  tci_rsp_if.sink     rsp,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tci_pkg::*;

  localparam int BLK = 64;
  localparam int S1 = 64;
  localparam int W1 = 4;
  localparam int S2 = 256;
  localparam int W2 = 8;

  typedef struct packed {
    logic [1:0] hit_level;
    logic [1:0] l1_eviction;
    logic [1:0] l2_eviction;
    logic       back_invalidated;
  } access_result_t;

  logic [19:0] l1_tag [S1*W1];
  logic        l1_vld [S1*W1];
  logic        l1_drt [S1*W1];
  logic [7:0]  l1_age [S1*W1];
  logic [17:0] l2_tag [S2*W2];
  logic        l2_vld [S2*W2];
  logic        l2_drt [S2*W2];
  logic [7:0]  l2_age [S2*W2];
  logic [15:0] lfsr;
  logic        use_lfsr;

  access_result_t pending_results [$];

  // Pick a victim way; steps the LFSR under random policy
  function automatic int choose_way(bit second, int base, int ways);
    int pick;
    logic [7:0] best;
    pick = 0;
    if (use_lfsr) begin
      pick = lfsr % ways;
      lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : 16'd0);
    end
    for (int w = 0; w < ways; w++)
      if (!(second ? l2_vld[base+w] : l1_vld[base+w])) return w;
    if (!use_lfsr) begin
      best = second ? l2_age[base] : l1_age[base];
      pick = 0;
      for (int w = 1; w < ways; w++)
        if ((second ? l2_age[base+w] : l1_age[base+w]) > best) begin
          best = second ? l2_age[base+w] : l1_age[base+w];
          pick = w;
        end
    end
    return pick;
  endfunction

  function automatic void grow_l1(int base);
    for (int w = 0; w < W1; w++) if (l1_age[base+w] != AGE_MAX) l1_age[base+w]++;
  endfunction

  function automatic void grow_l2(int base);
    for (int w = 0; w < W2; w++) if (l2_age[base+w] != AGE_MAX) l2_age[base+w]++;
  endfunction

  // Update the tag state for one access and return its result
  function automatic access_result_t cache_access(logic wr, logic [31:0] addr);
    access_result_t r;
    logic [25:0] blk;
    int b1, b2, hw, v1, v2, eb1;
    logic [25:0] eblk;
    blk = addr / BLK;
    b1 = (blk % S1) * W1;
    b2 = (blk % S2) * W2;
    r = '{HIT_NONE, EV_NONE, EV_NONE, 1'b0};
    hw = -1;
    for (int w = 0; w < W1; w++)
      if (hw < 0 && l1_vld[b1+w] && l1_tag[b1+w] == blk / S1) hw = w;
    if (hw >= 0) begin
      r.hit_level = HIT_L1;
      if (wr) l1_drt[b1+hw] = 1'b1;
      grow_l1(b1);
      l1_age[b1+hw] = '0;
      return r;
    end
    for (int w = 0; w < W2; w++)
      if (hw < 0 && l2_vld[b2+w] && l2_tag[b2+w] == blk / S2) hw = w;
    if (hw >= 0) begin
      r.hit_level = HIT_L2;
      if (wr) l2_drt[b2+hw] = 1'b1;
      grow_l2(b2);
      l2_age[b2+hw] = '0;
    end
    v1 = choose_way(1'b0, b1, W1);
    r.l1_eviction = !l1_vld[b1+v1] ? EV_NONE : l1_drt[b1+v1] ? EV_DIRTY : EV_CLEAN;
    grow_l1(b1);
    l1_tag[b1+v1] = 20'(blk / S1);
    l1_vld[b1+v1] = 1'b1;
    l1_drt[b1+v1] = wr;
    l1_age[b1+v1] = '0;
    if (r.hit_level == HIT_NONE) begin
      v2 = choose_way(1'b1, b2, W2) + b2;
      r.l2_eviction = !l2_vld[v2] ? EV_NONE : l2_drt[v2] ? EV_DIRTY : EV_CLEAN;
      grow_l2(b2);
      if (l2_vld[v2]) begin
        eblk = 26'(l2_tag[v2] * S2 + blk % S2);
        eb1 = (eblk % S1) * W1;
        for (int k = 0; k < W1; k++)
          if (!r.back_invalidated && l1_vld[eb1+k] && l1_tag[eb1+k] == eblk / S1) begin
            grow_l1(eb1);
            l1_vld[eb1+k] = 1'b0;
            l1_drt[eb1+k] = 1'b0;
            l1_age[eb1+k] = '0;
            r.back_invalidated = 1'b1;
          end
      end
      l2_tag[v2] = 18'(blk / S2);
      l2_vld[v2] = 1'b1;
      l2_drt[v2] = 1'b0;
      l2_age[v2] = '0;
    end
    return r;
  endfunction

  int mismatches;
  assign fail_count = mismatches;

  always @(posedge clk) begin
    access_result_t got, want;
    if (rst) begin
      for (int i = 0; i < S1*W1; i++) begin
        l1_vld[i] = '0; l1_drt[i] = '0; l1_age[i] = '0; l1_tag[i] = '0;
      end
      for (int i = 0; i < S2*W2; i++) begin
        l2_vld[i] = '0; l2_drt[i] = '0; l2_age[i] = '0; l2_tag[i] = '0;
      end
      lfsr = SEED_RESET;
      use_lfsr = 1'b0;
      mismatches = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_POLICY) use_lfsr = pwdata[0];
        else lfsr = pwdata[15:0];
      end
      // Compare a result with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit_level, rsp.l1_eviction, rsp.l2_eviction, rsp.back_invalidated};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      // Predict an accepted item
      if (req.valid && req.ready)
        pending_results.push_back(cache_access(req.mode, req.address));
    end
  end

  function automatic int outstanding();
    return pending_results.size();
  endfunction
endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tci_pkg::*;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count;
  int          items_in, results_out, idle_cycles;

  tci_req_if req ();
  tci_rsp_if rsp ();

  two_level_inclusive_cache_tags u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req(req.sink), .rsp(rsp.source)
  );

  cache_tags_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .req(req.sink), .rsp(rsp.sink), .fail_count
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Count traffic and idle cycles
  always @(posedge clk) begin
    if (rst) begin
      items_in <= 0; results_out <= 0; idle_cycles <= 0;
    end else begin
      if (req.valid && req.ready) items_in <= items_in + 1;
      if (rsp.valid && rsp.ready) results_out <= results_out + 1;
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (!rst && idle_cycles > 5000) begin
      $display("FAIL two_level_inclusive_cache_tags");
      $finish;
    end
  end

  // Stall the receiver on its own pattern
  initial begin
    int mode_r;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      mode_r = $urandom_range(0, 3);
      repeat ($urandom_range(1, 12)) begin
        if (mode_r == 0) rsp.ready = 1'b1;
        else if (mode_r == 1) rsp.ready = ($urandom_range(0, 3) != 0);
        else rsp.ready = 1'($urandom_range(0, 1));
        @(negedge clk);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  int burst_left;

  // Send one item, inserting random gaps between bursts
  task automatic send_access(logic wr, logic [31:0] addr);
    if (burst_left == 0) begin
      req.valid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid = 1; req.mode = wr; req.address = addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    req.valid = 0;
  endtask

  task automatic drain();
    while (results_out != items_in || u_chk.outstanding() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Address with a small tag pool so sets fill, hit and evict
  function automatic logic [31:0] pick_address(int pool);
    logic [31:0] a;
    a = 32'($urandom_range(0, pool - 1)) << 14;
    a[7:6] = 2'($urandom_range(0, 3));
    a[31] = a[31] ^ 1'($urandom_range(0, 1));
    a[5:0] = 6'($urandom_range(0, 63));
    return a;
  endfunction

  initial begin
    logic [15:0] seeds [4];
    seeds = '{16'd1, 16'd65535, 16'd44257, 16'h0000};
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    req.valid = 0; req.mode = 0; req.address = 0;
    burst_left = 0;
    repeat (9) @(negedge clk);
    rst = 0;

    // Directed: extremes, fill a set past both levels, dirty lines
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b0, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send_access(i[0], i << 14);
    for (int i = 0; i < 6; i++) send_access(1'b0, i << 14);
    send_access(1'b1, 32'h0000_1000);
    send_access(1'b0, 32'h0000_1000);
    drain();

    // Random phases across policies and seeds
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(3'd0 | (REG_POLICY << 2), 32'(ph[0]));
      reg_write(3'd0 | (REG_SEED << 2),
                (ph < 4) ? 32'(seeds[ph]) : 32'($urandom_range(1, 65535)));
      for (int n = 0; n < 215; n++) begin
        if ($urandom_range(0, 9) == 0) send_access(1'($urandom_range(0, 1)), $urandom);
        else send_access(1'($urandom_range(0, 1)), pick_address(ph < 4 ? 24 : 96));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS two_level_inclusive_cache_tags");
    end else begin
      $display("FAIL two_level_inclusive_cache_tags");
    end
    $finish;
  end
endmodule
